// ----- rtl/core/tme_pkg.sv -----
`timescale 1ns / 1ps

package tme_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_SINE_BITS = 16;

    localparam int SCALE_W      = 16;
    localparam int SCALE_FRAC   = 8;
    localparam int HALF_W       = 15;
    localparam int AMOUNT_W     = 16;
    localparam int FACTOR_W     = 31;   // distance_scale * |amount| < 2^31
    localparam int POS_W        = 32;
    localparam int HEAD_W       = 10;
    localparam int HMAG_W       = 16;   // |heading +/- amount| <= 33127
    localparam int HEAD_MOD     = 360;
    localparam int REM_STEPS    = 7;    // 360 << 6 is the largest multiple needed
    localparam int SINE_MAG_MAX = 23;
    localparam int SINE_ENTRIES = 91;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    localparam logic [HALF_W-1:0]  HALF_WIDTH_RST = 15'd256;
    localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd256;

    typedef enum logic [2:0] {
        MODE_FWD      = 3'd0,
        MODE_BWD      = 3'd1,
        MODE_RIGHT    = 3'd2,
        MODE_LEFT     = 3'd3,
        MODE_PEN_UP   = 3'd4,
        MODE_PEN_DOWN = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH = 1'b0,
        CFG_DIST_SCALE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_F = 2'd0,
        MUL_X = 2'd1,
        MUL_Y = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     ld_cmd;
        logic     prep;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     rnd_en;
        logic     rnd_y;
        logic     add_x;
        logic     add_y;
        logic     turn;
        logic     finish;
    } tme_cmd_t;

    typedef struct packed {
        logic is_move;
        logic is_turn;
        logic in_bounds;
        logic out_busy;
    } tme_stat_t;

    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } sine_idx_t;

    // Angle constants in Q60, used only while building the sine table
    localparam longint unsigned PiQ60   = 64'h3243_F6A8_885A_308D;
    localparam longint unsigned StepQ60 = PiQ60 / 180;
    localparam longint unsigned Mask30  = 64'h0000_0000_3FFF_FFFF;
    localparam longint unsigned TaylorDiv [1:12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
        longint unsigned ah, al, bh, bl;
        ah = a >> 30;
        al = a & Mask30;
        bh = b >> 30;
        bl = b & Mask30;
        return ah * bh + ((ah * bl + al * bh) >> 30);
    endfunction

    // sin(k deg) with frac fractional bits, Taylor series in Q60, round half up
    function automatic logic [SINE_MAG_MAX-1:0] sine_entry(int k, int frac);
        longint unsigned x, x2, term, sum, v, vmax;
        x    = StepQ60 * longint'(k);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++) begin
            term = mul_q60(term, x2) / TaylorDiv[n];
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v    = (sum + (64'd1 << (59 - frac))) >> (60 - frac);
        vmax = (64'd1 << frac) - 64'd1;
        if (v > vmax) begin
            v = vmax;
        end
        return SINE_MAG_MAX'(v);
    endfunction

    // Fold an angle in 0..359 onto the first-quadrant table
    function automatic sine_idx_t quad_index(logic [8:0] a);
        sine_idx_t q;
        priority if (a <= 9'd90) begin
            q.neg = 1'b0;
            q.idx = 7'(a);
        end else if (a <= 9'd180) begin
            q.neg = 1'b0;
            q.idx = 7'(9'd180 - a);
        end else if (a <= 9'd270) begin
            q.neg = 1'b1;
            q.idx = 7'(a - 9'd180);
        end else begin
            q.neg = 1'b1;
            q.idx = 7'(9'd360 - a);
        end
        return q;
    endfunction

endpackage

// ----- rtl/core/tme_ctrl.sv -----
`timescale 1ns / 1ps

module tme_ctrl
    import tme_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tme_stat_t stat,
    output tme_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PREP  = 9'b000000010,
        ST_MUL_F = 9'b000000100,
        ST_MUL_X = 9'b000001000,
        ST_MUL_Y = 9'b000010000,
        ST_ADD_X = 9'b000100000,
        ST_ADD_Y = 9'b001000000,
        ST_TURN  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_F;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.ld_cmd = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                priority if (stat.is_move && stat.in_bounds) begin
                    state_next = ST_MUL_F;
                end else if (stat.is_turn) begin
                    state_next = ST_TURN;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL_F: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_F;
                state_next  = ST_MUL_X;
            end
            ST_MUL_X: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_X;
                state_next  = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                // y product while the x product is rounded
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_Y;
                cmd.rnd_en  = 1'b1;
                state_next  = ST_ADD_X;
            end
            ST_ADD_X: begin
                cmd.add_x  = 1'b1;
                cmd.rnd_en = 1'b1;
                cmd.rnd_y  = 1'b1;
                state_next = ST_ADD_Y;
            end
            ST_ADD_Y: begin
                cmd.add_y  = 1'b1;
                state_next = ST_DONE;
            end
            ST_TURN: begin
                cmd.turn   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/tme_datapath.sv -----
`timescale 1ns / 1ps

module tme_datapath
    import tme_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int SINE_BITS = DEF_SINE_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tme_cmd_t                     cmd,
    output tme_stat_t                    stat,
    input  logic [2:0]                   s_mode,
    input  logic signed [AMOUNT_W-1:0]   s_amount,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic                         m_status,
    output logic                         m_vertex_valid,
    output logic signed [POS_W-1:0]      m_vertex_x,
    output logic signed [POS_W-1:0]      m_vertex_y,
    output logic signed [HEAD_W-1:0]     m_heading
);

    localparam int SM  = SINE_BITS - 1;
    localparam int AW  = (SM > SCALE_W) ? SM : SCALE_W;
    localparam int PW  = SM + FACTOR_W;
    localparam int SH  = SM + SCALE_FRAC - FRAC_BITS;
    localparam int LSH = (SH < 0) ? -SH : 0;
    localparam int RSH = (SH > 0) ? SH : 0;
    localparam int MW  = PW + 1 + LSH;
    localparam int DW  = MW + 1;
    localparam int SW  = DW + 1;
    localparam int LW  = (FRAC_BITS + HALF_W + 2 > POS_W + 1) ?
                         FRAC_BITS + HALF_W + 2 : POS_W + 1;

    // configuration and architectural state
    logic [HALF_W-1:0]         half_width_reg;
    logic [SCALE_W-1:0]        scale_reg;
    logic signed [POS_W-1:0]   pos_x_reg;
    logic signed [POS_W-1:0]   pos_y_reg;
    logic signed [HEAD_W-1:0]  heading_reg;
    logic                      pen_reg;
    logic                      m_valid_reg;

    // item and work registers
    logic [2:0]                mode_reg;
    logic signed [AMOUNT_W-1:0] amount_reg;
    logic                      amt_neg_reg;
    logic [AMOUNT_W-1:0]       amt_mag_reg;
    logic                      hneg_reg;
    logic [HMAG_W-1:0]         hmag_reg;
    sine_idx_t                 sin_q_reg;
    sine_idx_t                 cos_q_reg;
    logic                      inb_reg;
    logic [SM-1:0]             sx_reg;
    logic [SM-1:0]             sy_reg;
    logic [FACTOR_W-1:0]       f_reg;
    logic [PW-1:0]             prod_reg;
    logic signed [DW-1:0]      delta_reg;

    // output payload
    logic                      m_status_reg;
    logic                      m_vtx_reg;
    logic signed [POS_W-1:0]   m_x_reg;
    logic signed [POS_W-1:0]   m_y_reg;
    logic signed [HEAD_W-1:0]  m_heading_reg;

    logic is_move, is_turn, is_left, is_bwd;
    assign is_move = (mode_reg == MODE_FWD) || (mode_reg == MODE_BWD);
    assign is_turn = (mode_reg == MODE_RIGHT) || (mode_reg == MODE_LEFT);
    assign is_left = (mode_reg == MODE_LEFT);
    assign is_bwd  = (mode_reg == MODE_BWD);

    // quarter-wave sine magnitudes
    logic [SM-1:0] sine_rom [0:SINE_ENTRIES-1];
    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sine
        assign sine_rom[k] = SM'(sine_entry(k, SM));
    end

    // bounds check, strict on both sides
    logic signed [LW-1:0] lim, px, py;
    logic in_bounds;
    assign lim = LW'({half_width_reg, {FRAC_BITS{1'b0}}});
    assign px  = LW'(pos_x_reg);
    assign py  = LW'(pos_y_reg);
    assign in_bounds = (px < lim) && (px > -lim) && (py < lim) && (py > -lim);

    // heading sum and table angles
    logic signed [HMAG_W+1:0] hsum;
    logic [8:0] ang_a, ang_c;
    logic [9:0] ang_t;
    always_comb begin
        if (is_left) begin
            hsum = (HMAG_W+2)'(heading_reg) - (HMAG_W+2)'(amount_reg);
        end else begin
            hsum = (HMAG_W+2)'(heading_reg) + (HMAG_W+2)'(amount_reg);
        end
        if (heading_reg[HEAD_W-1]) begin
            ang_a = 9'(heading_reg + 10'sd360);
        end else begin
            ang_a = 9'(heading_reg);
        end
        ang_t = {1'b0, ang_a} + 10'd90;
        ang_c = (ang_t >= 10'd360) ? 9'(ang_t - 10'd360) : 9'(ang_t);
    end

    // shared multiplier
    logic [AW-1:0]          op_a;
    logic [FACTOR_W-1:0]    op_b;
    logic [AW+FACTOR_W-1:0] prod_full;
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_F: begin
                op_a = AW'(scale_reg);
                op_b = FACTOR_W'(amt_mag_reg);
            end
            MUL_X: begin
                op_a = AW'(sx_reg);
                op_b = f_reg;
            end
            MUL_Y: begin
                op_a = AW'(sy_reg);
                op_b = f_reg;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end
    assign prod_full = op_a * op_b;

    // bring the product to FRAC_BITS, ties away from zero on the magnitude
    logic [MW-1:0] rmag;
    if (RSH > 0) begin : g_rshift
        logic [PW:0] rsum;
        assign rsum = {1'b0, prod_reg} + ((PW+1)'(1) << (RSH - 1));
        assign rmag = MW'(rsum >> RSH);
    end else begin : g_lshift
        assign rmag = MW'(prod_reg) << LSH;
    end

    logic x_neg, y_neg, d_neg;
    logic signed [DW-1:0] delta_next;
    assign x_neg = sin_q_reg.neg ^ amt_neg_reg ^ is_bwd;
    assign y_neg = cos_q_reg.neg ^ amt_neg_reg ^ is_bwd;
    assign d_neg = cmd.rnd_y ? y_neg : x_neg;
    assign delta_next = d_neg ? -$signed(DW'(rmag)) : $signed(DW'(rmag));

    // saturating position add
    logic signed [POS_W-1:0] pos_sel, pos_next;
    logic signed [SW-1:0]    pos_sum;
    logic [SW-POS_W:0]       sum_hi;
    always_comb begin
        pos_sel = cmd.add_y ? pos_y_reg : pos_x_reg;
        pos_sum = SW'(pos_sel) + SW'(delta_reg);
        sum_hi  = pos_sum[SW-1:POS_W-1];
        priority if ((&sum_hi) || (~|sum_hi)) begin
            pos_next = POS_W'(pos_sum);
        end else if (pos_sum[SW-1]) begin
            pos_next = POS_MIN;
        end else begin
            pos_next = POS_MAX;
        end
    end

    // heading remainder by restoring subtraction of 360 * 2^k
    logic [HMAG_W-1:0]        rem;
    logic signed [HEAD_W-1:0] heading_next;
    always_comb begin
        rem = hmag_reg;
        for (int k = REM_STEPS - 1; k >= 0; k--) begin
            if (rem >= (HMAG_W'(HEAD_MOD) << k)) begin
                rem = rem - (HMAG_W'(HEAD_MOD) << k);
            end
        end
        heading_next = hneg_reg ? -$signed(HEAD_W'(rem)) : $signed(HEAD_W'(rem));
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= HALF_WIDTH_RST;
            scale_reg      <= SCALE_RST;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            heading_reg    <= '0;
            pen_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_HALF_WIDTH) begin
                    half_width_reg <= cfg_data[HALF_W-1:0];
                end
                if (cfg_index == CFG_DIST_SCALE) begin
                    scale_reg <= cfg_data[SCALE_W-1:0];
                end
            end
            if (cmd.add_x) begin
                pos_x_reg <= pos_next;
            end
            if (cmd.add_y) begin
                pos_y_reg <= pos_next;
            end
            if (cmd.turn) begin
                heading_reg <= heading_next;
            end
            if (cmd.finish && (mode_reg == MODE_PEN_UP)) begin
                pen_reg <= 1'b0;
            end
            if (cmd.finish && (mode_reg == MODE_PEN_DOWN)) begin
                pen_reg <= 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // work and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.ld_cmd) begin
            mode_reg   <= s_mode;
            amount_reg <= s_amount;
        end
        if (cmd.prep) begin
            amt_neg_reg <= amount_reg[AMOUNT_W-1];
            amt_mag_reg <= amount_reg[AMOUNT_W-1] ? AMOUNT_W'(-amount_reg)
                                                  : AMOUNT_W'(amount_reg);
            hneg_reg    <= hsum[HMAG_W+1];
            hmag_reg    <= hsum[HMAG_W+1] ? HMAG_W'(-hsum) : HMAG_W'(hsum);
            sin_q_reg   <= quad_index(ang_a);
            cos_q_reg   <= quad_index(ang_c);
            inb_reg     <= in_bounds;
        end
        if (cmd.mul_en && (cmd.mul_sel == MUL_F)) begin
            f_reg  <= FACTOR_W'(prod_full);
            sx_reg <= sine_rom[sin_q_reg.idx];
            sy_reg <= sine_rom[cos_q_reg.idx];
        end
        if (cmd.mul_en && (cmd.mul_sel != MUL_F)) begin
            prod_reg <= PW'(prod_full);
        end
        if (cmd.rnd_en) begin
            delta_reg <= delta_next;
        end
        if (cmd.finish) begin
            m_status_reg  <= is_move && !inb_reg;
            m_vtx_reg     <= pen_reg && ((is_move && inb_reg) || is_turn);
            m_x_reg       <= pos_x_reg;
            m_y_reg       <= pos_y_reg;
            m_heading_reg <= heading_reg;
        end
    end

    assign stat.is_move   = is_move;
    assign stat.is_turn   = is_turn;
    assign stat.in_bounds = in_bounds;
    assign stat.out_busy  = m_valid_reg && !m_ready;

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_vertex_valid = m_vtx_reg;
    assign m_vertex_x     = m_x_reg;
    assign m_vertex_y     = m_y_reg;
    assign m_heading      = m_heading_reg;

endmodule

// ----- rtl/core/turtle_motion_engine_top.sv -----
// Each accepted item is prepared first. A move in bounds then goes through the multiply,
// add x and add y states, a turn through the turn state, and any other item (a refused
// move too) straight to done. Items are taken one at a time; a move makes three passes
// through the shared multiplier (scale * distance, sin, cos).
// A finished result waits in the output register; the next item is taken once it is loaded.
// Reset (aresetn, synchronous, active low): position 0, heading 0, pen up,
// half_width 256, distance_scale 256, no result pending.
`timescale 1ns / 1ps

module turtle_motion_engine_top
    import tme_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int SINE_BITS = DEF_SINE_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_mode,
    input  logic signed [AMOUNT_W-1:0]  s_amount,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic                        m_vertex_valid,
    output logic signed [POS_W-1:0]     m_vertex_x,
    output logic signed [POS_W-1:0]     m_vertex_y,
    output logic signed [HEAD_W-1:0]    m_heading,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    tme_cmd_t  cmd;
    tme_stat_t stat;

    assign cfg_ready = 1'b1;

    tme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tme_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .SINE_BITS (SINE_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_mode         (s_mode),
        .s_amount       (s_amount),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_status       (m_status),
        .m_vertex_valid (m_vertex_valid),
        .m_vertex_x     (m_vertex_x),
        .m_vertex_y     (m_vertex_y),
        .m_heading      (m_heading)
    );

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while the previous one is still in work");

    a_refused_no_vertex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_vertex_valid)
        else $error("refused move reports a vertex");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_heading <= 10'sd359) && (m_heading >= -10'sd359))
        else $error("heading out of range");

endmodule

// ----- tb/sv/turtle_pose_checker.sv -----
`timescale 1ns / 1ps

module turtle_pose_checker
    import tme_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int SINE_BITS = DEF_SINE_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [2:0]                 s_mode,
    input  logic signed [AMOUNT_W-1:0] s_amount,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic                       m_status,
    input  logic                       m_vertex_valid,
    input  logic signed [POS_W-1:0]    m_vertex_x,
    input  logic signed [POS_W-1:0]    m_vertex_y,
    input  logic signed [HEAD_W-1:0]   m_heading,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         mismatch_count,
    output int                         poses_pending,
    output int                         poses_checked,
    output int                         moves_refused,
    output int                         vertices_seen
);

    localparam real    PI         = 3.14159265358979323846;
    localparam longint SINE_ONE   = 64'sd1 <<< (SINE_BITS - 1);
    // product of sine (Q.SINE_BITS-1) and scale (Q8.8) back to position fraction
    localparam int     PROD_SHIFT = SINE_BITS - 1 + SCALE_FRAC - FRAC_BITS;

    typedef struct {
        logic                     status;
        logic                     vertex;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] heading;
    } pose_t;

    longint                  sine_q [0:90];
    pose_t                   expected_poses [$];
    pose_t                   want;

    logic signed [POS_W-1:0] tx;
    logic signed [POS_W-1:0] ty;
    int                      head_deg;
    logic                    pen;
    logic [HALF_W-1:0]       bound_units;
    logic [SCALE_W-1:0]      step_scale;

    initial begin
        mismatch_count = 0;
        poses_checked  = 0;
        moves_refused  = 0;
        vertices_seen  = 0;
        for (int k = 0; k <= 90; k++) begin
            sine_q[k] = longint'($floor($sin(k * PI / 180.0) * SINE_ONE + 0.5));
            if (sine_q[k] > SINE_ONE - 1) begin
                sine_q[k] = SINE_ONE - 1;
            end
        end
    end

    task automatic report_mismatch(string what, longint got, longint exp_val);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    function automatic longint sine_of(int deg);
        int a;
        a = deg % HEAD_MOD;
        if (a < 0) begin
            a += HEAD_MOD;
        end
        if (a <= 90) return sine_q[a];
        if (a <= 180) return sine_q[180 - a];
        if (a <= 270) return -sine_q[a - 180];
        return -sine_q[360 - a];
    endfunction

    // round to nearest, ties away from zero
    function automatic longint to_q_frac(longint p);
        longint mag;
        mag = (p < 0) ? -p : p;
        if (PROD_SHIFT > 0) begin
            mag = (mag + (64'sd1 <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
        end else if (PROD_SHIFT < 0) begin
            mag = mag <<< (-PROD_SHIFT);
        end
        return (p < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > longint'(POS_MAX)) return POS_MAX;
        if (v < longint'(POS_MIN)) return POS_MIN;
        return POS_W'(v);
    endfunction

    function automatic void advance_turtle(logic [2:0] mode, logic signed [AMOUNT_W-1:0] amount);
        pose_t  next;
        longint lim;
        longint step_len;
        longint dx;
        longint dy;
        next.status = 1'b0;
        next.vertex = 1'b0;
        case (mode)
            MODE_FWD, MODE_BWD: begin
                lim = longint'(bound_units) <<< FRAC_BITS;
                if (longint'(tx) > -lim && longint'(tx) < lim &&
                    longint'(ty) > -lim && longint'(ty) < lim) begin
                    step_len = longint'(step_scale) * longint'(amount);
                    dx   = to_q_frac(sine_of(head_deg) * step_len);
                    dy   = to_q_frac(sine_of(head_deg + 90) * step_len);
                    if (mode == MODE_BWD) begin
                        dx = -dx;
                        dy = -dy;
                    end
                    tx = clamp_pos(longint'(tx) + dx);
                    ty = clamp_pos(longint'(ty) + dy);
                    next.vertex = pen;
                end else begin
                    next.status = 1'b1;
                end
            end
            MODE_RIGHT: begin
                head_deg    = (head_deg + int'(amount)) % HEAD_MOD;
                next.vertex = pen;
            end
            MODE_LEFT: begin
                head_deg    = (head_deg - int'(amount)) % HEAD_MOD;
                next.vertex = pen;
            end
            MODE_PEN_UP:   pen = 1'b0;
            MODE_PEN_DOWN: pen = 1'b1;
            default: ;
        endcase
        next.x       = tx;
        next.y       = ty;
        next.heading = HEAD_W'(head_deg);
        expected_poses.push_back(next);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            tx          = '0;
            ty          = '0;
            head_deg    = 0;
            pen         = 1'b0;
            bound_units = HALF_WIDTH_RST;
            step_scale  = SCALE_RST;
            expected_poses.delete();
            poses_pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HALF_WIDTH: bound_units = cfg_data[HALF_W-1:0];
                    CFG_DIST_SCALE: step_scale  = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                poses_checked++;
                if (expected_poses.size() == 0) begin
                    report_mismatch("result with no command pending", 0, 0);
                end else begin
                    want = expected_poses.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_vertex_valid !== want.vertex)
                        report_mismatch("vertex_valid", m_vertex_valid, want.vertex);
                    if (m_vertex_x !== want.x)
                        report_mismatch("vertex_x", m_vertex_x, want.x);
                    if (m_vertex_y !== want.y)
                        report_mismatch("vertex_y", m_vertex_y, want.y);
                    if (m_heading !== want.heading)
                        report_mismatch("heading", m_heading, want.heading);
                    if (want.status) moves_refused++;
                    if (want.vertex) vertices_seen++;
                end
            end
            if (s_valid && s_ready) begin
                advance_turtle(s_mode, s_amount);
            end
            poses_pending <= expected_poses.size();
        end
    end

endmodule

// ----- tb/sv/tb_turtle_motion_engine_top.sv -----
`timescale 1ns / 1ps

module tb_turtle_motion_engine_top;
    import tme_pkg::*;

    localparam int     CLK_HALF       = 6;
    localparam int     RESET_CYCLES   = 10;
    localparam int     N_DIRECTED     = 24;
    localparam int     N_PHASES       = 8;
    localparam int     PHASE_ITEMS    = 152;
    localparam int     RX_HOLD_CYCLES = 300;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     TAIL_CYCLES    = 16;
    localparam longint RUN_LIMIT_NS   = 6_000_000;
    localparam int     PICK_RANDOM    = -1;

    // modes the block must ignore
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [2:0]                 s_mode;
    logic signed [AMOUNT_W-1:0] s_amount;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_status;
    logic                       m_vertex_valid;
    logic signed [POS_W-1:0]    m_vertex_x;
    logic signed [POS_W-1:0]    m_vertex_y;
    logic signed [HEAD_W-1:0]   m_heading;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int mismatch_count;
    int poses_pending;
    int poses_checked;
    int moves_refused;
    int vertices_seen;

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    logic [2:0] dir_mode [N_DIRECTED] = '{
        MODE_PEN_DOWN, MODE_FWD, MODE_RIGHT, MODE_FWD, MODE_LEFT, MODE_BWD,
        MODE_FWD, MODE_RIGHT, MODE_LEFT, MODE_LEFT, MODE_RIGHT, MODE_RIGHT,
        MODE_FWD, MODE_SPARE_A, MODE_SPARE_B, MODE_PEN_UP, MODE_FWD, MODE_PEN_DOWN,
        MODE_FWD, MODE_FWD, MODE_BWD, MODE_FWD, MODE_LEFT, MODE_PEN_UP
    };
    int dir_amount [N_DIRECTED] = '{
        0, 10, 90, 20, 45, 7,
        -3, 32767, -32768, 32767, -32768, 0,
        0, 32767, -32768, -1, 1, 12345,
        1000, 5, -32768, 32767, 90, 0
    };

    int phase_bound [N_PHASES] = '{32767, 1, 32767, 0, 32767, 20000, PICK_RANDOM, 32767};
    int phase_scale [N_PHASES] = '{256, 256, 65535, 0, 1, 128, PICK_RANDOM, 0};

    turtle_motion_engine_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_amount       (s_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_vertex_valid (m_vertex_valid),
        .m_vertex_x     (m_vertex_x),
        .m_vertex_y     (m_vertex_y),
        .m_heading      (m_heading),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    turtle_pose_checker pose_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_amount       (s_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_vertex_valid (m_vertex_valid),
        .m_vertex_x     (m_vertex_x),
        .m_vertex_y     (m_vertex_y),
        .m_heading      (m_heading),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .poses_pending  (poses_pending),
        .poses_checked  (poses_checked),
        .moves_refused  (moves_refused),
        .vertices_seen  (vertices_seen)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    task automatic send_cmd(logic [2:0] mode, logic signed [AMOUNT_W-1:0] amt);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_amount <= amt;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (poses_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = RX_HOLD_CYCLES;
            end else begin
                gap = idle_on ? $urandom_range(0, 11) : 0;
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        int                         hw;
        int                         sc;
        int                         move_max;
        int                         pick;
        logic signed [AMOUNT_W-1:0] amt;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_mode    <= MODE_FWD;
        s_amount  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_HALF_WIDTH;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config, extremes of amount, ignored modes, out of bounds
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_cmd(dir_mode[i], AMOUNT_W'(dir_amount[i]));
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drain();
            hw = (phase_bound[p] == PICK_RANDOM) ? $urandom_range(1, 32767) : phase_bound[p];
            sc = (phase_scale[p] == PICK_RANDOM) ? $urandom_range(0, 65535) : phase_scale[p];
            // bit 15 of the half width write is don't-care
            write_reg(CFG_HALF_WIDTH, {1'($urandom_range(0, 1)), HALF_W'(hw)});
            write_reg(CFG_DIST_SCALE, SCALE_W'(sc));
            // keep step size modest so the turtle stays well inside the widest bounds
            move_max = (sc <= 4) ? 32767 : 131072 / sc;
            idle_on  = (p % 3) != 2;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 40) begin
                    hold_req = 1'b1;
                    idle_on  = 1'b0;
                end
                if (p == 2 && i == 70) idle_on = 1'b1;
                if (p == 4 && i == 75) wait_drain();

                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    if (move_max >= 32767) begin
                        amt = AMOUNT_W'($urandom);
                    end else begin
                        amt = AMOUNT_W'(int'($urandom_range(0, 2 * move_max)) - move_max);
                    end
                    send_cmd((pick < 22) ? MODE_FWD : MODE_BWD, amt);
                end else if (pick < 72) begin
                    case ($urandom_range(0, 3))
                        0: amt = AMOUNT_W'(45 * (int'($urandom_range(0, 32)) - 16));
                        1: amt = AMOUNT_W'(int'($urandom_range(0, 720)) - 360);
                        2: amt = AMOUNT_W'($urandom);
                        default: amt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    endcase
                    send_cmd((pick < 56) ? MODE_RIGHT : MODE_LEFT, amt);
                end else if (pick < 96) begin
                    send_cmd((pick < 86) ? MODE_PEN_DOWN : MODE_PEN_UP, AMOUNT_W'($urandom));
                end else begin
                    send_cmd((pick < 98) ? MODE_SPARE_A : MODE_SPARE_B, AMOUNT_W'($urandom));
                end
            end
        end

        // largest scale and distance: position saturates, then stays out of bounds
        wait_drain();
        write_reg(CFG_HALF_WIDTH, 16'hFFFF);
        write_reg(CFG_DIST_SCALE, 16'hFFFF);
        idle_on = 1'b1;
        send_cmd(MODE_PEN_DOWN, 16'sd0);
        send_cmd(MODE_RIGHT, 16'sd45);
        send_cmd(MODE_FWD, 16'sh7FFF);
        send_cmd(MODE_BWD, 16'sh8000);
        send_cmd(MODE_LEFT, 16'sd180);
        send_cmd(MODE_RIGHT, 16'sd359);
        send_cmd(MODE_PEN_UP, 16'sd0);
        send_cmd(MODE_FWD, 16'sd1);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Covered %0d drawing commands across %0d register settings, both registers at their extremes.",
                 poses_checked, N_PHASES + 2);
        $display("Results: %0d moves refused out of bounds, %0d vertices emitted, %0d mismatches.",
                 moves_refused, vertices_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("Timeout: results still outstanding or handshake stuck");
        $display("Some tests failed");
        $finish;
    end

endmodule
